// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers used by the lru_recency_tracker rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/lrt_pkg.sv
// ----------------------------------------------------------------------------
// lrt_pkg
// shared constants and control types of the lru recency tracker
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam int WAYS   = 4;
  localparam int KEY_W  = 8;
  localparam int RANK_W = 2;
  localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int OCC_W  = $clog2(WAYS + 1);

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_key;
    logic update;
  } lrt_cmd_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } lrt_state_t;

endpackage

// File: src/lru_recency_tracker.sv
// ----------------------------------------------------------------------------
// lru_recency_tracker
// least-recently-used tracker for a small cache of keyed entries
// ----------------------------------------------------------------------------
// usage:
//   input channel  in_valid / in_stall carries one access key per beat
//   output channel out_valid / out_stall carries hit, hit_rank, evict_valid
//   and evict_key, one beat per access, in access order
//   an access goes through S_IDLE, which takes the key, and S_UPDATE, which does
//   the parallel compare against all resident keys and the move-to-front update
//   and loads the result register; in_stall is high in S_UPDATE, so the next
//   key is taken only after the update of the access before it
//   the next key is taken while a result still waits in the output register
//   if out_stall stays high, the update of the following access waits in the
//   controller until the result register frees up, and in_stall holds high
//   reset (rst, synchronous) empties the cache: occupancy goes to zero and
//   the output channel goes idle; no clearing pass is needed
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_recency_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lrt_pkg::KEY_W-1:0]   key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic [lrt_pkg::RANK_W-1:0]  hit_rank,
  output logic                        evict_valid,
  output logic [lrt_pkg::KEY_W-1:0]   evict_key
);

  lrt_pkg::lrt_cmd_t cmd;

  // sequencer
  lrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // key store and compare logic
  lrt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .key         (key),
    .hit         (hit),
    .hit_rank    (hit_rank),
    .evict_valid (evict_valid),
    .evict_key   (evict_key)
  );

  // checks
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_IMPLIES(a_evict_only_on_miss, clk, rst, out_valid && evict_valid, !hit)
  `ASSERT_IMPLIES(a_miss_rank_zero, clk, rst, out_valid && !hit, hit_rank == '0)
  `ASSERT_IMPLIES(a_no_evict_key_zero, clk, rst, out_valid && !evict_valid, evict_key == '0)

endmodule

// File: src/lrt_ctrl.sv
// ----------------------------------------------------------------------------
// lrt_ctrl
// sequencer for one access: take the key, then update the list and load the
// result register once the output side has room
// ----------------------------------------------------------------------------
module lrt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lrt_pkg::lrt_cmd_t cmd
);

  lrt_pkg::lrt_state_t state, state_next;
  logic                out_free;

  // result register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  assign in_stall     = (state != lrt_pkg::S_IDLE);
  assign cmd.load_key = (state == lrt_pkg::S_IDLE) && in_valid;
  assign cmd.update   = (state == lrt_pkg::S_UPDATE) && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lrt_pkg::S_IDLE: begin
        if (in_valid) state_next = lrt_pkg::S_UPDATE;
      end
      lrt_pkg::S_UPDATE: begin
        if (out_free) state_next = lrt_pkg::S_IDLE;
      end
      default: state_next = lrt_pkg::S_IDLE;
    endcase
  end

  // state and output beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lrt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.update) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// File: src/lrt_datapath.sv
// ----------------------------------------------------------------------------
// lrt_datapath
// recency-ordered key registers, occupancy count, parallel key compare and
// the result register
// ----------------------------------------------------------------------------
module lrt_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  lrt_pkg::lrt_cmd_t           cmd,
  input  logic [lrt_pkg::KEY_W-1:0]   key,
  output logic                        hit,
  output logic [lrt_pkg::RANK_W-1:0]  hit_rank,
  output logic                        evict_valid,
  output logic [lrt_pkg::KEY_W-1:0]   evict_key
);

  logic [lrt_pkg::KEY_W-1:0] key_reg;
  logic [lrt_pkg::KEY_W-1:0] keys [lrt_pkg::WAYS];
  logic [lrt_pkg::OCC_W-1:0] occ;

  logic [lrt_pkg::WAYS-1:0]  match;
  logic                      found;
  logic [lrt_pkg::IDX_W-1:0] rank;
  logic                      full;
  logic [lrt_pkg::RANK_W-1:0] rank_sat;

  // compare against every resident position
  always_comb begin
    for (int i = 0; i < lrt_pkg::WAYS; i++) begin
      match[i] = (lrt_pkg::OCC_W'(i) < occ) && (keys[i] == key_reg);
    end
  end

  // first matching position is the hit rank
  always_comb begin
    found = 1'b0;
    rank  = '0;
    for (int i = lrt_pkg::WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        rank  = lrt_pkg::IDX_W'(i);
      end
    end
  end

  assign full = (occ == lrt_pkg::OCC_W'(lrt_pkg::WAYS));

  // rank saturates at the top of the output field
  always_comb begin
    if (32'(rank) > 3) rank_sat = '1;
    else rank_sat = lrt_pkg::RANK_W'(rank);
  end

  // latch the accepted key
  always_ff @(posedge clk) begin
    if (cmd.load_key) key_reg <= key;
  end

  // move to front: on a hit only the more recent keys shift back
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      keys[0] <= key_reg;
      for (int i = 1; i < lrt_pkg::WAYS; i++) begin
        if (!found || (lrt_pkg::IDX_W'(i) <= rank)) keys[i] <= keys[i-1];
      end
    end
  end

  // occupancy grows on a miss until full
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.update && !found && !full) begin
      occ <= occ + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit         <= found;
      hit_rank    <= found ? rank_sat : '0;
      evict_valid <= !found && full;
      evict_key   <= (!found && full) ? keys[lrt_pkg::WAYS-1] : '0;
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lru recency tracker: every accepted access key
// goes through a behavioral lru list kept in a scoreboard class, and each
// result beat is checked against the oldest predicted result, field by field
// ----------------------------------------------------------------------------
module testbench;

  localparam int LRU_WAYS   = lrt_pkg::WAYS;
  localparam int KW         = lrt_pkg::KEY_W;
  localparam int RW         = lrt_pkg::RANK_W;
  localparam int RAND_BEATS = 1650;
  localparam int MAX_REPORTS = 10;

  // one result beat of the tracker
  typedef struct packed {
    logic          hit;
    logic [RW-1:0] rank;
    logic          evicted;
    logic [KW-1:0] victim;
  } access_result_t;

  // lru list prediction and result checking
  class lru_scoreboard;
    logic [KW-1:0]  resident [LRU_WAYS];
    int unsigned    fill = 0;
    access_result_t due_q[$];
    int unsigned    errors = 0;
    int unsigned    reports = 0;
    int unsigned    checked = 0;
    int unsigned    hits = 0;
    int unsigned    evictions = 0;
    int unsigned    rank_seen [4] = '{0, 0, 0, 0};

    function int unsigned pending();
      return due_q.size();
    endfunction

    // work out the result of one accepted access and update the list
    function void note_access(logic [KW-1:0] k);
      access_result_t r;
      int             pos;
      int             i;
      int             top;
      r   = '0;
      pos = 0;
      for (i = 0; i < int'(fill); i++) begin
        if (!r.hit && resident[i] == k) begin
          r.hit = 1'b1;
          pos   = i;
        end
      end
      if (r.hit) begin
        top    = pos;
        r.rank = (pos > 3) ? RW'(3) : RW'(pos);
        hits++;
        rank_seen[r.rank]++;
      end else if (fill >= LRU_WAYS) begin
        top       = LRU_WAYS - 1;
        r.evicted = 1'b1;
        r.victim  = resident[LRU_WAYS-1];
        evictions++;
      end else begin
        top = fill;
        fill++;
      end
      // move the keys ahead of the slot one position back, key goes to front
      for (i = top; i > 0; i--)
        resident[i] = resident[i-1];
      resident[0] = k;
      due_q.push_back(r);
    endfunction

    // compare one result beat against the oldest prediction
    function void check_result(access_result_t got);
      access_result_t want;
      checked++;
      if (due_q.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("ERROR: result beat with nothing expected: hit=%0d rank=%0d ev=%0d key=%0d",
                   got.hit, got.rank, got.evicted, got.victim);
        end
        return;
      end
      want = due_q.pop_front();
      if (got.hit !== want.hit || got.rank !== want.rank ||
          got.evicted !== want.evicted || got.victim !== want.victim) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("ERROR: beat %0d expected hit=%0d rank=%0d ev=%0d key=%0d",
                   checked, want.hit, want.rank, want.evicted, want.victim);
          $display("       beat %0d actual   hit=%0d rank=%0d ev=%0d key=%0d",
                   checked, got.hit, got.rank, got.evicted, got.victim);
        end
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [KW-1:0] key = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          hit;
  logic [RW-1:0] hit_rank;
  logic          evict_valid;
  logic [KW-1:0] evict_key;

  lru_scoreboard sb;
  bit            idling_on = 1'b1;

  lru_recency_tracker DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .key         (key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .hit_rank    (hit_rank),
    .evict_valid (evict_valid),
    .evict_key   (evict_key)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watch both channels and drive random output stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_access(key);
      if (out_valid && !out_stall)
        sb.check_result('{hit, hit_rank, evict_valid, evict_key});
    end
    out_stall <= idling_on && ($urandom_range(99) < 15);
  end

  // present one key and hold it until the beat is taken
  task automatic send_key(input logic [KW-1:0] k);
    if (idling_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    key      <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  logic [KW-1:0] directed_keys [22] = '{
    8'd0, 8'd255, 8'd0, 8'd0, 8'd170, 8'd85, 8'd255, 8'd170, 8'd0,
    8'd1, 8'd2, 8'd128, 8'd0, 8'd64, 8'd32, 8'd16, 8'd8, 8'd4,
    8'd4, 8'd255, 8'd85, 8'd4
  };

  // stimulus: directed corners, then pools of recurring keys with noise
  initial begin
    logic [KW-1:0] pool [6];
    int            pool_n;
    int            n;
    int            j;
    sb = new;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_keys[n])
      send_key(directed_keys[n]);

    pool_n = 4;
    for (n = 0; n < RAND_BEATS; n++) begin
      idling_on = !(n >= 600 && n < 1000);
      // a new working set every 50 beats, sized around the way count
      if (n % 50 == 0) begin
        pool_n = $urandom_range(3, 6);
        for (j = 0; j < 6; j++)
          pool[j] = KW'($urandom_range(255));
      end
      if ($urandom_range(99) < 80)
        send_key(pool[$urandom_range(pool_n - 1)]);
      else
        send_key(KW'($urandom_range(255)));
    end
    in_valid  <= 1'b0;
    idling_on = 1'b1;

    // drain, then wait on for any stray beat
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d accesses: %0d hits (rank 0..3: %0d %0d %0d %0d), %0d evictions",
             sb.checked, sb.hits, sb.rank_seen[0], sb.rank_seen[1],
             sb.rank_seen[2], sb.rank_seen[3], sb.evictions);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS lru_recency_tracker");
    else
      $display("FAIL lru_recency_tracker");
    $finish;
  end

  // hard limit on run time
  initial begin
    #2ms;
    $display("timeout waiting for the tracker");
    $display("FAIL lru_recency_tracker");
    $finish;
  end

endmodule

// File: lru_recency_tracker.f
+incdir+src
src/lrt_pkg.sv
src/lrt_ctrl.sv
src/lrt_datapath.sv
src/lru_recency_tracker.sv
bench/testbench.sv
